// File: src/trie_insert_and_lookup_defines.svh
// ---------------------------------------------------------------------------
// Trie insert and lookup - assertion macros
// Shared property wrappers for the checker. All are clocked on i_clk and
// disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef TRIE_INSERT_AND_LOOKUP_DEFINES_SVH
`define TRIE_INSERT_AND_LOOKUP_DEFINES_SVH

// Invariant that holds at every edge out of reset
`define TIL_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Condition in one cycle that forces a consequence in the next
`define TIL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/til_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Trie insert and lookup - package
// Table sizes, derived widths, the node row type and the action codes.
// ---------------------------------------------------------------------------
package til_pkg;

    // Table geometry
    localparam int NODE_COUNT    = 4096;
    localparam int ALPHABET_SIZE = 26;

    // Derived widths
    localparam int NODE_W   = $clog2(NODE_COUNT);
    localparam int FREE_W   = NODE_W + 1;
    localparam int LETTER_W = 5;
    localparam int LANE_W   = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int ROW_W    = ALPHABET_SIZE * NODE_W;

    // One node: a child link per letter, zero meaning no child
    typedef logic [ALPHABET_SIZE-1:0][NODE_W-1:0] t_row;

    // Action codes
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

endpackage

// File: src/trie_insert_and_lookup.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Trie insert and lookup - top level
// Character trie in a node table: letters in, one result per word out.
// ---------------------------------------------------------------------------
// Words arrive one letter per word on the input channel, each tagged insert
// or search, with last_letter closing the word; only the closing letter
// yields a result (found, status). Each letter is read, then acted on: S_IDLE
// reads the current node's link row from the link memory, S_EVAL acts on it. A
// letter that allocates a node also passes through S_CLEAR, as the single port
// of the link memory needs a further write to zero the new node's row. A
// closing search letter whose walk succeeded also passes through S_LOOK, for
// the read of the word-end memory. After reset the block clears the root row
// in S_INIT before it takes a word. Nodes are handed out in order; rows are
// zeroed when allocated, so only allocated rows are ever read. Results sit in
// an output register and one hold stage, so the next word may arrive while a result waits.
// ---------------------------------------------------------------------------
module trie_insert_and_lookup (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_action,
    input  logic [til_pkg::LETTER_W-1:0]  i_letter,
    input  logic                          i_last_letter,
    // output channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_found,
    output logic                          o_status
);
    import til_pkg::*;

    typedef enum logic [4:0] {
        S_INIT  = 5'b00001,
        S_IDLE  = 5'b00010,
        S_EVAL  = 5'b00100,
        S_CLEAR = 5'b01000,
        S_LOOK  = 5'b10000
    } t_state;

    // Control state
    t_state              r_state, n_state;
    logic [NODE_W-1:0]   r_cursor, n_cursor;
    logic [FREE_W-1:0]   r_free, n_free;
    logic                r_miss, n_miss;
    logic                r_full, n_full;
    logic                r_pend, n_pend;
    logic                r_o_valid, n_o_valid;

    // Payload registers
    logic                r_action, n_action;
    logic [LETTER_W-1:0] r_letter, n_letter;
    logic                r_last, n_last;
    logic [NODE_W-1:0]   r_new_node, n_new_node;
    logic                r_pend_found, n_pend_found;
    logic                r_pend_status, n_pend_status;
    logic                r_o_found, n_o_found;
    logic                r_o_status, n_o_status;

    // Memory ports
    logic                lnk_we;
    logic [NODE_W-1:0]   lnk_addr;
    t_row                lnk_wdata, lnk_rdata;
    logic                end_we;
    logic [NODE_W-1:0]   end_addr;
    logic                end_wdata, end_rdata;

    // Step decode
    logic                out_free, in_ready, in_acc;
    logic [LANE_W-1:0]   lane;
    logic                in_range, table_full;
    logic [NODE_W-1:0]   link, alloc_node;
    logic [NODE_W-1:0]   step_cursor;
    logic                step_miss, step_full, step_alloc;

    // Link rows, one per node
    til_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NODE_COUNT)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (lnk_we),
        .i_addr  (lnk_addr),
        .i_wdata (lnk_wdata),
        .o_rdata (lnk_rdata)
    );

    // Word-end marks, one per node
    til_ram #(
        .WIDTH (1),
        .DEPTH (NODE_COUNT)
    ) u_end_ram (
        .i_clk   (i_clk),
        .i_we    (end_we),
        .i_addr  (end_addr),
        .i_wdata (end_wdata),
        .o_rdata (end_rdata)
    );

    // Handshake
    assign out_free = !r_o_valid || !i_stall;
    assign in_ready = (r_state == S_IDLE) && (!r_pend || out_free);
    assign in_acc   = i_valid && in_ready;
    assign o_stall  = !in_ready;

    // Link lookup for the held letter
    assign in_range   = (r_letter < ALPHABET_SIZE);
    assign lane       = LANE_W'(r_letter);
    assign link       = in_range ? lnk_rdata[lane] : '0;
    assign table_full = (r_free == FREE_W'(NODE_COUNT));
    assign alloc_node = r_free[NODE_W-1:0];

    // Walk one letter against the row just read
    always_comb begin
        step_cursor = r_cursor;
        step_miss   = r_miss;
        step_full   = r_full;
        step_alloc  = 1'b0;
        if (!r_miss) begin
            if (!in_range) begin
                step_miss = 1'b1;
            end else if (link != '0) begin
                step_cursor = link;
            end else if (r_action == ACT_SEARCH) begin
                step_miss = 1'b1;
            end else if (!table_full) begin
                step_alloc  = 1'b1;
                step_cursor = alloc_node;
            end else begin
                step_full = 1'b1;
                step_miss = 1'b1;
            end
        end
    end

    // Sequencer, memory control and result staging
    always_comb begin
        n_state       = r_state;
        n_cursor      = r_cursor;
        n_free        = r_free;
        n_miss        = r_miss;
        n_full        = r_full;
        n_pend        = r_pend;
        n_o_valid     = r_o_valid;
        n_action      = r_action;
        n_letter      = r_letter;
        n_last        = r_last;
        n_new_node    = r_new_node;
        n_pend_found  = r_pend_found;
        n_pend_status = r_pend_status;
        n_o_found     = r_o_found;
        n_o_status    = r_o_status;

        lnk_we    = 1'b0;
        lnk_addr  = r_cursor;
        lnk_wdata = lnk_rdata;
        end_we    = 1'b0;
        end_addr  = r_cursor;
        end_wdata = 1'b0;

        // output register takes the held result when it can
        if (out_free) begin
            n_o_valid = r_pend;
            if (r_pend) begin
                n_o_found  = r_pend_found;
                n_o_status = r_pend_status;
            end
            n_pend = 1'b0;
        end

        case (r_state)
            S_INIT: begin
                // zero the root row
                lnk_we    = 1'b1;
                lnk_addr  = '0;
                lnk_wdata = '0;
                end_we    = 1'b1;
                end_addr  = '0;
                n_state   = S_IDLE;
            end
            S_IDLE: begin
                // read of the cursor row is issued with the accept
                if (in_acc) begin
                    n_action = i_action;
                    n_letter = i_letter;
                    n_last   = i_last_letter;
                    n_state  = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = S_IDLE;
                if (step_alloc) begin
                    // link the new node into the parent row
                    lnk_we          = 1'b1;
                    lnk_addr        = r_cursor;
                    lnk_wdata[lane] = alloc_node;
                    end_we          = 1'b1;
                    end_addr        = alloc_node;
                    end_wdata       = r_last;
                    n_free          = r_free + FREE_W'(1);
                    n_new_node      = alloc_node;
                    n_state         = S_CLEAR;
                end
                if (r_last) begin
                    n_pend_found  = 1'b0;
                    n_pend_status = 1'b0;
                    if (r_action == ACT_SEARCH) begin
                        if (step_miss) begin
                            n_pend = 1'b1;
                        end else begin
                            end_addr = step_cursor;
                            n_state  = S_LOOK;
                        end
                    end else begin
                        n_pend = 1'b1;
                        if (step_full) begin
                            n_pend_status = 1'b1;
                        end else if (!step_miss) begin
                            end_we       = 1'b1;
                            end_addr     = step_cursor;
                            end_wdata    = 1'b1;
                            n_pend_found = 1'b1;
                        end
                    end
                    n_cursor = '0;
                    n_miss   = 1'b0;
                    n_full   = 1'b0;
                end else begin
                    n_cursor = step_cursor;
                    n_miss   = step_miss;
                    n_full   = step_full;
                end
            end
            S_CLEAR: begin
                // a fresh node starts with no children
                lnk_we    = 1'b1;
                lnk_addr  = r_new_node;
                lnk_wdata = '0;
                n_state   = S_IDLE;
            end
            S_LOOK: begin
                n_pend        = 1'b1;
                n_pend_found  = end_rdata;
                n_pend_status = 1'b0;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_cursor  <= '0;
            r_free    <= FREE_W'(1);
            r_miss    <= 1'b0;
            r_full    <= 1'b0;
            r_pend    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cursor  <= n_cursor;
            r_free    <= n_free;
            r_miss    <= n_miss;
            r_full    <= n_full;
            r_pend    <= n_pend;
            r_o_valid <= n_o_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_action      <= n_action;
        r_letter      <= n_letter;
        r_last        <= n_last;
        r_new_node    <= n_new_node;
        r_pend_found  <= n_pend_found;
        r_pend_status <= n_pend_status;
        r_o_found     <= n_o_found;
        r_o_status    <= n_o_status;
    end

    assign o_valid  = r_o_valid;
    assign o_found  = r_o_found;
    assign o_status = r_o_status;

endmodule

// File: src/til_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Trie insert and lookup - generic RAM
// Single-port synchronous RAM, one write or read a cycle, registered read
// data (old contents on a write).
// ---------------------------------------------------------------------------
module til_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/til_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Trie insert and lookup - port checker
// Watches the top-level ports: result words only follow closing letters,
// never more than the block can hold, and a stalled result stays put.
// ---------------------------------------------------------------------------
`include "trie_insert_and_lookup_defines.svh"

module til_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic                          i_action,
    input logic [til_pkg::LETTER_W-1:0]  i_letter,
    input logic                          i_last_letter,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic                          o_found,
    input logic                          o_status
);
    import til_pkg::*;

    logic       in_close, out_take;
    logic [1:0] r_owed;
    logic       in_word_ok;

    assign in_close   = i_valid && !o_stall && i_last_letter;
    assign out_take   = o_valid && !i_stall;
    assign in_word_ok = (i_action == ACT_INSERT) || (i_action == ACT_SEARCH)
                        || (i_letter != '0);

    // Closing letters accepted but not yet answered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owed <= '0;
        end else if (in_close && in_word_ok && !out_take) begin
            r_owed <= r_owed + 2'd1;
        end else if (out_take && !in_close) begin
            r_owed <= r_owed - 2'd1;
        end
    end

    `TIL_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_found) && $stable(o_status), "stalled result changed")
    `TIL_ASSERT_RST(a_found_status, !(o_valid && o_found && o_status), "found and table-full together")
    `TIL_ASSERT_RST(a_no_spurious, !o_valid || (r_owed != 2'd0), "result without a closing letter")
    `TIL_ASSERT_RST(a_owed_bound, r_owed != 2'd3, "too many results outstanding")

endmodule

bind trie_insert_and_lookup til_checker u_til_checker (.*);

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Trie insert and lookup - testbench
// Sends keys one letter per word and checks every result word in order
// against a trie model kept in the bench. A short table of directed words
// comes first. Random keys follow, most of them well formed and the rest
// noise, with stored keys searched and inserted again. Both sides idle at
// random, and once the receiver holds off long enough to back the block up
// to its input.
// ---------------------------------------------------------------------------
module tb_top;
    import til_pkg::*;

    localparam int IDLE_PCT     = 16;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 500;
    localparam int MAX_KEY      = 16;
    localparam int SLOT_W       = $clog2(NODE_COUNT * ALPHABET_SIZE);

    // One expected result word
    typedef struct packed {
        logic found;
        logic status;
    } t_verdict;

    // One key: letters from index 0 up, len of them used
    typedef struct packed {
        logic [MAX_KEY-1:0][LETTER_W-1:0] ltrs;
        logic [4:0]                       len;
    } t_key;

    // Directed table row; typed rows carry their own expected result
    typedef struct packed {
        logic                act;
        logic [LETTER_W-1:0] ltr;
        logic                last;
        logic                typed;
        logic                found;
        logic                status;
    } t_stim_row;

    localparam int DIR_ROWS = 23;
    localparam t_stim_row DIR_TABLE [DIR_ROWS] = '{
        // search of an empty trie
        '{ACT_SEARCH, 5'd0,  1'b1, 1'b1, 1'b0, 1'b0},
        // insert then search a single letter
        '{ACT_INSERT, 5'd0,  1'b1, 1'b1, 1'b1, 1'b0},
        '{ACT_SEARCH, 5'd0,  1'b1, 1'b1, 1'b1, 1'b0},
        // top letter, then its prefix and a longer miss
        '{ACT_INSERT, 5'd25, 1'b0, 1'b0, 1'b0, 1'b0},
        '{ACT_INSERT, 5'd25, 1'b1, 1'b1, 1'b1, 1'b0},
        '{ACT_SEARCH, 5'd25, 1'b1, 1'b0, 1'b0, 1'b0},
        '{ACT_SEARCH, 5'd25, 1'b0, 1'b0, 1'b0, 1'b0},
        '{ACT_SEARCH, 5'd25, 1'b0, 1'b0, 1'b0, 1'b0},
        '{ACT_SEARCH, 5'd25, 1'b1, 1'b0, 1'b0, 1'b0},
        // letters out of range
        '{ACT_INSERT, 5'd0,  1'b0, 1'b0, 1'b0, 1'b0},
        '{ACT_INSERT, 5'd31, 1'b1, 1'b1, 1'b0, 1'b0},
        '{ACT_SEARCH, 5'd26, 1'b1, 1'b1, 1'b0, 1'b0},
        // mixed actions within one key
        '{ACT_INSERT, 5'd16, 1'b0, 1'b0, 1'b0, 1'b0},
        '{ACT_SEARCH, 5'd1,  1'b1, 1'b0, 1'b0, 1'b0},
        '{ACT_SEARCH, 5'd0,  1'b0, 1'b0, 1'b0, 1'b0},
        '{ACT_INSERT, 5'd9,  1'b1, 1'b0, 1'b0, 1'b0},
        '{ACT_SEARCH, 5'd0,  1'b0, 1'b0, 1'b0, 1'b0},
        '{ACT_SEARCH, 5'd9,  1'b1, 1'b0, 1'b0, 1'b0},
        '{ACT_SEARCH, 5'd0,  1'b0, 1'b0, 1'b0, 1'b0},
        '{ACT_SEARCH, 5'd9,  1'b0, 1'b0, 1'b0, 1'b0},
        '{ACT_SEARCH, 5'd10, 1'b1, 1'b0, 1'b0, 1'b0},
        // bad letter first, valid letter after it
        '{ACT_INSERT, 5'd31, 1'b0, 1'b0, 1'b0, 1'b0},
        '{ACT_INSERT, 5'd0,  1'b1, 1'b0, 1'b0, 1'b0}
    };

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic                i_action;
    logic [LETTER_W-1:0] i_letter;
    logic                i_last_letter;
    logic                o_valid;
    logic                i_stall;
    logic                o_found;
    logic                o_status;

    // Trie model state
    logic [NODE_W-1:0] link_mem [NODE_COUNT*ALPHABET_SIZE];
    logic              word_end_mem [NODE_COUNT];
    logic [FREE_W-1:0] next_free;
    logic [NODE_W-1:0] walk_node;
    logic              walk_lost;
    logic              walk_full;

    t_verdict word_verdicts [$];
    t_key     stored_keys [$];

    int  fail_count       = 0;
    int  verdicts_checked = 0;
    int  letters_sent     = 0;
    int  hold_left        = 0;
    bit  held_off         = 1'b0;
    logic quiet_span;

    trie_insert_and_lookup dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_action      (i_action),
        .i_letter      (i_letter),
        .i_last_letter (i_last_letter),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_found       (o_found),
        .o_status      (o_status)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // no idling on either side through this span
    assign quiet_span = (letters_sent >= 250) && (letters_sent < 400);

    // Trie walk for one letter; a closing letter yields the result word
    function automatic void walk_trie_letter(input logic act, input logic [LETTER_W-1:0] ltr,
                                             input logic last, output logic has_verdict,
                                             output t_verdict v);
        logic [SLOT_W-1:0] slot;
        logic [NODE_W-1:0] child;
        has_verdict = 1'b0;
        v = '0;
        if (!walk_lost) begin
            if (ltr >= ALPHABET_SIZE) begin
                walk_lost = 1'b1;
            end else begin
                slot  = SLOT_W'(int'(walk_node) * ALPHABET_SIZE + int'(ltr));
                child = link_mem[slot];
                if (child == '0) begin
                    if (act == ACT_SEARCH) begin
                        walk_lost = 1'b1;
                    end else if (next_free < NODE_COUNT) begin
                        link_mem[slot] = next_free[NODE_W-1:0];
                        walk_node      = next_free[NODE_W-1:0];
                        next_free      = next_free + 1'b1;
                    end else begin
                        walk_full = 1'b1;
                        walk_lost = 1'b1;
                    end
                end else begin
                    walk_node = child;
                end
            end
        end
        if (last) begin
            has_verdict = 1'b1;
            if (act == ACT_SEARCH) begin
                v.found = !walk_lost && word_end_mem[walk_node];
            end else if (walk_full) begin
                v.status = 1'b1;
            end else if (!walk_lost) begin
                word_end_mem[walk_node] = 1'b1;
                v.found = 1'b1;
            end
            walk_node = '0;
            walk_lost = 1'b0;
            walk_full = 1'b0;
        end
    endfunction

    // Random key; hi bounds the letters (a small alphabet gives shared prefixes)
    function automatic t_key make_key(input int len, input int hi);
        t_key k;
        k = '0;
        k.len = 5'(len);
        for (int i = 0; i < len; i++) begin
            k.ltrs[i] = LETTER_W'($urandom_range(0, hi));
        end
        return k;
    endfunction

    // Offer one letter word; called and left at a falling edge
    task automatic send_letter(input logic act, input logic [LETTER_W-1:0] ltr, input logic last,
                               input logic typed, input logic t_found, input logic t_status);
        logic     has_verdict;
        t_verdict v;
        while (!quiet_span && ($urandom_range(0, 99) < IDLE_PCT)) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_action      <= act;
        i_letter      <= ltr;
        i_last_letter <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        walk_trie_letter(act, ltr, last, has_verdict, v);
        if (has_verdict) begin
            if (typed) begin
                v.found  = t_found;
                v.status = t_status;
            end
            word_verdicts = {word_verdicts, v};
        end
        letters_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_key(input t_key k, input logic act);
        for (int i = 0; i < k.len; i++) begin
            send_letter(act, k.ltrs[i], (i == k.len - 1), 1'b0, 1'b0, 1'b0);
        end
    endtask

    // Pick a stored key, sometimes cut to a prefix
    function automatic t_key pick_stored();
        t_key k;
        k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
        if ($urandom_range(0, 4) == 0) begin
            k.len = 5'($urandom_range(1, k.len));
        end
        return k;
    endfunction

    // Receiver: random stalls, one long hold-off once results are flowing
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else if (!held_off && (verdicts_checked >= 40)) begin
                held_off  = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= !quiet_span && ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    // Result checker
    always @(posedge i_clk) begin : check_results
        t_verdict want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (word_verdicts.size() == 0) begin
                $error("unexpected result: found %0b status %0b", o_found, o_status);
                fail_count++;
            end else begin
                want = word_verdicts.pop_front();
                if (o_found !== want.found) begin
                    $error("found: expected %0b, got %0b", want.found, o_found);
                    fail_count++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0b, got %0b", want.status, o_status);
                    fail_count++;
                end
                verdicts_checked++;
            end
        end
    end

    // Stimulus
    initial begin : stimulus
        t_key k;
        int   pick;
        int   len;
        logic act;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_action      = ACT_INSERT;
        i_letter      = '0;
        i_last_letter = 1'b0;
        link_mem      = '{default: '0};
        word_end_mem  = '{default: 1'b0};
        next_free = FREE_W'(1);
        walk_node = '0;
        walk_lost = 1'b0;
        walk_full = 1'b0;

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (int r = 0; r < DIR_ROWS; r++) begin
            send_letter(DIR_TABLE[r].act, DIR_TABLE[r].ltr, DIR_TABLE[r].last,
                        DIR_TABLE[r].typed, DIR_TABLE[r].found, DIR_TABLE[r].status);
        end

        // random keys: mostly well formed, some noise
        while (letters_sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if ((pick < 30) && (stored_keys.size() > 0)) begin
                send_key(pick_stored(), ACT_SEARCH);
            end else if ((pick < 45) && (stored_keys.size() > 0)) begin
                send_key(pick_stored(), ACT_INSERT);
            end else if (pick < 85) begin
                k   = make_key($urandom_range(1, 6), $urandom_range(0, 1) ? 3 : ALPHABET_SIZE - 1);
                act = 1'($urandom_range(0, 1));
                send_key(k, act);
                if (act == ACT_INSERT) stored_keys = {stored_keys, k};
            end else begin
                len = $urandom_range(1, 5);
                for (int i = 0; i < len; i++) begin
                    send_letter(1'($urandom_range(0, 1)), LETTER_W'($urandom_range(0, 31)),
                                (i == len - 1), 1'b0, 1'b0, 1'b0);
                end
            end
        end

        i_valid <= 1'b0;
        while (word_verdicts.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #4_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
